// ===== design/amfq_pkg.sv =====
// Package for the aging frame descriptor queue.
// Holds the entry record, operation, status and register codes and reset values.
// Standalone; used by aging_mac_frame_queue.
`default_nettype none

package amfq_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int OP_W   = 3;
   localparam int TICK_W = 32;
   localparam int HDL_W  = 16;
   localparam int TID_W  = 4;
   localparam int ADDR_W = 48;
   localparam int STAT_W = 2;
   localparam int CNT5_W = 5;

   localparam logic [OP_W-1:0] OP_ENQUEUE    = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_DEQUEUE    = 3'd2;
   localparam logic [OP_W-1:0] OP_MATCH_DEQ  = 3'd3;
   localparam logic [OP_W-1:0] OP_MATCH_PEEK = 3'd4;
   localparam logic [OP_W-1:0] OP_MATCH_CNT  = 3'd5;
   localparam logic [OP_W-1:0] OP_PEEK       = 3'd6;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NONE   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

   localparam logic [1:0] CSR_MAX_DELAY   = 2'd0;
   localparam logic [1:0] CSR_DROP_OLDEST = 2'd1;
   localparam logic [1:0] CSR_QUEUE_LIMIT = 2'd2;

   localparam logic [TICK_W-1:0] MAX_DELAY_RST   = 32'd500000;
   localparam logic [CNT5_W-1:0] QUEUE_LIMIT_RST = 5'd16;

   typedef struct packed {
      logic [HDL_W-1:0]  handle;
      logic [ADDR_W-1:0] rx;
      logic [ADDR_W-1:0] tx;
      logic [TID_W-1:0]  tid;
      logic              qos;
      logic [TICK_W-1:0] stamp;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/aging_mac_frame_queue.sv =====
// Aging frame descriptor queue: ordered entries with lifetime drop.
// Uses amfq_pkg for the entry record and all codes.
`default_nettype none

// Operations are taken on start when busy is low; one result beat comes back
// on rsp_valid for one cycle and cannot be held off. Entries sit compacted in a
// single-port-write memory with a registered read, head at address 0. A single
// sequencer walks it: each entry visited takes a read, then a stale/match
// check, each entry moved while closing a gap or opening the head takes a
// read and a write, and each removal ends with one more check step. The
// worst case is a scan that finds every entry stale, compacting after each.
module aging_mac_frame_queue
   import amfq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [TICK_W-1:0]  req_now_tick,
   input  wire logic [HDL_W-1:0]   req_packet_handle,
   input  wire logic [TID_W-1:0]   req_traffic_id,
   input  wire logic               req_qos_flag,
   input  wire logic [ADDR_W-1:0]  req_receiver_addr,
   input  wire logic [ADDR_W-1:0]  req_transmitter_addr,
   input  wire logic               req_address_select,
   input  wire logic [ADDR_W-1:0]  req_match_addr,
   output      logic               rsp_valid,
   output      logic [STAT_W-1:0]  rsp_status,
   output      logic [HDL_W-1:0]   rsp_out_handle,
   output      logic [TID_W-1:0]   rsp_out_tid,
   output      logic               rsp_out_qos,
   output      logic [ADDR_W-1:0]  rsp_out_receiver,
   output      logic [CNT5_W-1:0]  rsp_match_count,
   output      logic [CNT5_W-1:0]  rsp_expired_dropped,
   output      logic               rsp_evicted_head,
   output      logic [CNT5_W-1:0]  rsp_occupancy,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [TICK_W-1:0]  csr_wdata
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > CNT5_W) ? CW : CNT5_W;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_RD         = 4'd1;
   localparam logic [3:0] S_EV         = 4'd2;
   localparam logic [3:0] S_SH_RD      = 4'd3;
   localparam logic [3:0] S_SH_WR      = 4'd4;
   localparam logic [3:0] S_POST_STALE = 4'd5;
   localparam logic [3:0] S_POST_EVICT = 4'd6;
   localparam logic [3:0] S_INS_RD     = 4'd7;
   localparam logic [3:0] S_INS_WR     = 4'd8;
   localparam logic [3:0] S_INS_PUT    = 4'd9;
   localparam logic [3:0] S_DONE       = 4'd10;

   localparam logic [1:0] RET_SCAN   = 2'd0;
   localparam logic [1:0] RET_STALE  = 2'd1;
   localparam logic [1:0] RET_EVICT  = 2'd2;
   localparam logic [1:0] RET_FINISH = 2'd3;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   entry_type     wr_data;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         ret_ff, ret_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      i_ff, i_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      mcount_ff, mcount_in;
   logic [CW-1:0]      expired_ff, expired_in;
   logic               evicted_ff, evicted_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [HDL_W-1:0]   o_handle_ff, o_handle_in;
   logic [TID_W-1:0]   o_tid_ff, o_tid_in;
   logic               o_qos_ff, o_qos_in;
   logic [ADDR_W-1:0]  o_rx_ff, o_rx_in;

   logic [TICK_W-1:0]  max_delay_ff;
   logic               drop_oldest_ff;
   logic [CNT5_W-1:0]  queue_limit_ff;

   entry_type          new_ent_ff;
   logic               sel_ff;
   logic [ADDR_W-1:0]  maddr_ff;

   logic               accept;
   logic               stale_w, match_w, full_w, is_ins;
   logic [LW-1:0]      lim_w;
   logic [CW-1:0]      j_inc, i_inc;
   logic [ADDR_W-1:0]  sel_addr;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign j_inc  = CW'(j_ff + 1'b1);
   assign i_inc  = CW'(i_ff + 1'b1);
   assign is_ins = (op_ff == OP_ENQUEUE) || (op_ff == OP_PUSH_FRONT);

   assign stale_w  = TICK_W'(new_ent_ff.stamp - rd_data_ff.stamp) > max_delay_ff;
   assign sel_addr = sel_ff ? rd_data_ff.tx : rd_data_ff.rx;
   assign match_w  = rd_data_ff.qos && (rd_data_ff.tid == new_ent_ff.tid)
                     && (sel_addr == maddr_ff);

   always_comb begin
      lim_w = LW'(queue_limit_ff);
      if (lim_w == '0) lim_w = LW'(1);
      if (lim_w > LW'(CAPACITY)) lim_w = LW'(CAPACITY);
   end
   assign full_w = LW'(cnt_ff) >= lim_w;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      op_in       = op_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      mcount_in   = mcount_ff;
      expired_in  = expired_ff;
      evicted_in  = evicted_ff;
      status_in   = status_ff;
      o_handle_in = o_handle_ff;
      o_tid_in    = o_tid_ff;
      o_qos_in    = o_qos_ff;
      o_rx_in     = o_rx_ff;
      rd_addr     = i_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_addr     = j_ff[IW-1:0];
      wr_data     = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_operation;
               i_in        = '0;
               mcount_in   = '0;
               expired_in  = '0;
               evicted_in  = 1'b0;
               o_handle_in = '0;
               o_tid_in    = '0;
               o_qos_in    = 1'b0;
               o_rx_in     = '0;
               status_in   = (req_operation == OP_MATCH_CNT) ? STATUS_OK : STATUS_NONE;
               case (req_operation) inside
                  OP_ENQUEUE, OP_PUSH_FRONT: state_in = full_w ? S_RD : S_POST_EVICT;
                  OP_DEQUEUE, OP_MATCH_DEQ, OP_MATCH_PEEK, OP_MATCH_CNT, OP_PEEK:
                     state_in = S_RD;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            if (i_ff < cnt_ff) begin
               state_in = S_EV;
            end else begin
               state_in = is_ins ? S_POST_STALE : S_DONE;
            end
         end
         S_EV: begin
            state_in = S_RD;
            i_in     = i_inc;
            if (is_ins) begin
               if (stale_w) begin
                  expired_in = CW'(1);
                  j_in       = i_ff;
                  ret_in     = RET_STALE;
                  state_in   = S_SH_RD;
               end
            end else if (op_ff == OP_PEEK) begin
               if (!stale_w) begin
                  o_handle_in = rd_data_ff.handle;
                  o_tid_in    = rd_data_ff.tid;
                  o_qos_in    = rd_data_ff.qos;
                  o_rx_in     = rd_data_ff.rx;
                  status_in   = STATUS_OK;
                  state_in    = S_DONE;
               end
            end else if (stale_w) begin
               // drop it and look again at the same slot
               expired_in = CW'(expired_ff + 1'b1);
               i_in       = i_ff;
               j_in       = i_ff;
               ret_in     = RET_SCAN;
               state_in   = S_SH_RD;
            end else if (op_ff == OP_DEQUEUE || match_w) begin
               if (op_ff == OP_MATCH_CNT) begin
                  mcount_in = CW'(mcount_ff + 1'b1);
               end else begin
                  o_handle_in = rd_data_ff.handle;
                  o_tid_in    = rd_data_ff.tid;
                  o_qos_in    = rd_data_ff.qos;
                  o_rx_in     = rd_data_ff.rx;
                  status_in   = STATUS_OK;
                  if (op_ff == OP_MATCH_PEEK) begin
                     state_in = S_DONE;
                  end else begin
                     j_in     = i_ff;
                     ret_in   = RET_FINISH;
                     state_in = S_SH_RD;
                  end
               end
            end
         end
         S_SH_RD: begin
            if (j_inc < cnt_ff) begin
               rd_addr  = j_inc[IW-1:0];
               state_in = S_SH_WR;
            end else begin
               cnt_in = CW'(cnt_ff - 1'b1);
               case (ret_ff)
                  RET_SCAN:  state_in = S_RD;
                  RET_STALE: state_in = S_POST_STALE;
                  RET_EVICT: state_in = S_POST_EVICT;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_SH_WR: begin
            wr_en    = 1'b1;
            j_in     = j_inc;
            state_in = S_SH_RD;
         end
         S_POST_STALE: begin
            if (full_w && drop_oldest_ff) begin
               evicted_in = 1'b1;
               j_in       = '0;
               ret_in     = RET_EVICT;
               state_in   = S_SH_RD;
            end else begin
               state_in = S_POST_EVICT;
            end
         end
         S_POST_EVICT: begin
            if (full_w) begin
               status_in = STATUS_REJECT;
               state_in  = S_DONE;
            end else begin
               j_in     = cnt_ff;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            // push front opens slot 0 by moving entries up from the tail
            if (op_ff == OP_PUSH_FRONT && j_ff != '0) begin
               rd_addr  = IW'(j_ff - 1'b1);
               state_in = S_INS_WR;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            j_in     = CW'(j_ff - 1'b1);
            state_in = S_INS_RD;
         end
         S_INS_PUT: begin
            wr_en     = 1'b1;
            wr_data   = new_ent_ff;
            cnt_in    = CW'(cnt_ff + 1'b1);
            status_in = STATUS_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ret_ff         <= RET_SCAN;
         op_ff          <= OP_ENQUEUE;
         cnt_ff         <= '0;
         i_ff           <= '0;
         j_ff           <= '0;
         mcount_ff      <= '0;
         expired_ff     <= '0;
         evicted_ff     <= 1'b0;
         status_ff      <= STATUS_OK;
         max_delay_ff   <= MAX_DELAY_RST;
         drop_oldest_ff <= 1'b0;
         queue_limit_ff <= QUEUE_LIMIT_RST;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         op_ff      <= op_in;
         cnt_ff     <= cnt_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         mcount_ff  <= mcount_in;
         expired_ff <= expired_in;
         evicted_ff <= evicted_in;
         status_ff  <= status_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_DELAY:   max_delay_ff   <= csr_wdata;
               CSR_DROP_OLDEST: drop_oldest_ff <= csr_wdata[0];
               CSR_QUEUE_LIMIT: queue_limit_ff <= csr_wdata[CNT5_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      o_handle_ff <= o_handle_in;
      o_tid_ff    <= o_tid_in;
      o_qos_ff    <= o_qos_in;
      o_rx_ff     <= o_rx_in;
      if (accept) begin
         new_ent_ff.handle <= req_packet_handle;
         new_ent_ff.rx     <= req_receiver_addr;
         new_ent_ff.tx     <= req_transmitter_addr;
         new_ent_ff.tid    <= req_traffic_id;
         new_ent_ff.qos    <= req_qos_flag;
         new_ent_ff.stamp  <= req_now_tick;
         sel_ff            <= req_address_select;
         maddr_ff          <= req_match_addr;
      end
   end

   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_status          = status_ff;
   assign rsp_out_handle      = o_handle_ff;
   assign rsp_out_tid         = o_tid_ff;
   assign rsp_out_qos         = o_qos_ff;
   assign rsp_out_receiver    = o_rx_ff;
   assign rsp_match_count     = CNT5_W'(mcount_ff);
   assign rsp_expired_dropped = CNT5_W'(expired_ff);
   assign rsp_evicted_head    = evicted_ff;
   assign rsp_occupancy       = CNT5_W'(cnt_ff);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("queue count above capacity");

   a_beat_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result beat not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted operation did not raise busy");

endmodule

`default_nettype wire
